// ----- src/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier: the input and
// result beat layouts, the configuration set and the register indexes.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // widths fixed by the field definitions
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] HOLDOFF_RST    = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

    // one poll of the button
    typedef struct packed {
        logic              button_level;
        logic [TIME_W-1:0] now_ms;
    } t_bpc_in;

    // classification flags after one poll
    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_bpc_out;

    // configuration seen by the classifier core
    typedef struct packed {
        logic [CFG_W-1:0] holdoff_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_bpc_cfg;

endpackage

// ----- src/bpc_fsm.sv -----
// ----------------------------------------------------------------------------
// bpc_fsm
// Debounce and classification state machine. Holds the phase, the time mark
// and both flags, and advances them by one poll whenever i_step is high.
// The flags after the poll are presented combinationally on o_result.
// ----------------------------------------------------------------------------
module bpc_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bpc_pkg::t_bpc_in  i_poll,
    input  bpc_pkg::t_bpc_cfg i_cfg,
    output bpc_pkg::t_bpc_out o_result
);
    import bpc_pkg::*;

    // phase codes
    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_PRESS_HOLD   = 3'd1;
    localparam logic [2:0] PH_PRESSED      = 3'd2;
    localparam logic [2:0] PH_LONG_HELD    = 3'd3;
    localparam logic [2:0] PH_RELEASE_HOLD = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [TIME_W-1:0] r_mark, n_mark;
    logic              r_short_flag, n_short_flag;
    logic              r_long_flag, n_long_flag;

    logic [TIME_W-1:0] w_elapsed;
    logic              w_past_holdoff;
    logic              w_past_long;

    // wrapping elapsed time and the two threshold compares
    assign w_elapsed      = i_poll.now_ms - r_mark;
    assign w_past_holdoff = w_elapsed > {{(TIME_W-CFG_W){1'b0}}, i_cfg.holdoff_ms};
    assign w_past_long    = w_elapsed > {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms};

    // next phase, mark and flags for this poll
    always_comb begin
        n_phase      = r_phase;
        n_mark       = r_mark;
        n_short_flag = r_short_flag;
        n_long_flag  = r_long_flag;
        unique case (r_phase)
            PH_IDLE: begin
                n_short_flag = 1'b0;
                n_long_flag  = 1'b0;
                if (i_poll.button_level) begin
                    n_phase = PH_PRESS_HOLD;
                    n_mark  = i_poll.now_ms;
                end
            end
            PH_PRESS_HOLD: begin
                if (w_past_holdoff && i_poll.button_level) begin
                    n_phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (!i_poll.button_level) begin
                    // a late release is ignored until the button reads high again
                    if (!w_past_long) begin
                        n_short_flag = 1'b1;
                        n_mark       = i_poll.now_ms;
                        n_phase      = PH_RELEASE_HOLD;
                    end
                end else if (w_past_long) begin
                    n_long_flag = 1'b1;
                    n_phase     = PH_LONG_HELD;
                end
            end
            PH_LONG_HELD: begin
                if (!i_poll.button_level) begin
                    n_mark  = i_poll.now_ms;
                    n_phase = PH_RELEASE_HOLD;
                end
            end
            PH_RELEASE_HOLD: begin
                if (w_past_holdoff) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // state update, one poll per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_mark       <= '0;
            r_short_flag <= 1'b0;
            r_long_flag  <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_mark       <= n_mark;
            r_short_flag <= n_short_flag;
            r_long_flag  <= n_long_flag;
        end
    end

    assign o_result.short_press = n_short_flag;
    assign o_result.long_press  = n_long_flag;

    // a press is never both short and long
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_short_flag && r_long_flag))
        else $error("short and long flags set together");

    // the long-held phase is only reached with the long flag set
    a_long_held_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LONG_HELD) |-> r_long_flag)
        else $error("long-held phase without long flag");

    // during the press holdoff no classification has been made yet
    a_holdoff_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRESS_HOLD) |-> (!r_short_flag && !r_long_flag))
        else $error("flag set during press holdoff");

    // state only moves on a step
    a_hold_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_mark))
        else $error("state changed without a step");

endmodule

// ----- src/button_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced short and long button press recognizer, one poll per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one poll per
//   beat: the sampled button level and a wrapping millisecond time stamp.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one beat per poll with the short and long press flags after that poll.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_idx / i_cfg_data)
//   writes holdoff_ms (index 0) or long_press_ms (index 1); other indexes
//   are dropped. Write only while no poll is in flight.
//   Throughput: one poll per cycle, sustained while i_out_ready stays high.
//   A poll accepted into the input register is classified combinationally
//   by the core and loaded into the result register when that register is
//   free or draining, and its result beat is valid from there. The input
//   register and the result register each hold one beat, so a poll is still
//   taken while a result waits; with the receiver stalled, at most two polls
//   are held and o_in_ready then drops until the result beat leaves.
//   Reset (synchronous, active low) returns the machine to idle with both
//   flags clear, the time mark at zero, holdoff 50 ms, long press 1000 ms.
// ----------------------------------------------------------------------------
module button_press_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bpc_pkg::t_bpc_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bpc_pkg::t_bpc_out              o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]      i_cfg_data
);
    import bpc_pkg::*;

    t_bpc_cfg  r_cfg;
    logic      r_in_valid;
    t_bpc_in   r_in;
    logic      r_out_valid;
    t_bpc_out  r_out;
    logic      w_adv;
    t_bpc_out  w_result;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holdoff_ms    <= HOLDOFF_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_idx)
                CFG_HOLDOFF:    r_cfg.holdoff_ms    <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // a held poll moves on when the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // classifier core
    bpc_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_poll   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a held poll is kept until the core takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("held poll lost");

    // a waiting result beat is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result beat changed");

    // every step of the core produces a result beat
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("step without result beat");

endmodule
